FILE: rtl/snb_pkg.sv
// ----------------------------------------------------------------------------
// snb_pkg: shared types and constants for the sigmoid neuron backprop unit
// Beat layouts, command and register codes, saturation helpers and the
// sigmoid sample function that builds the lookup table at elaboration.
// ----------------------------------------------------------------------------
package snb_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_WEIGHT     = 3'd0,
    CMD_FORWARD_INPUT   = 3'd1,
    CMD_OUTPUT_GRADIENT = 3'd2,
    CMD_HIDDEN_TERM     = 3'd3,
    CMD_UPDATE_INPUT    = 3'd4
  } cmd_e;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM      = 1'd1;
  localparam logic [16:0] LEARNING_RATE_RST = 17'd45875;  // 0.7
  localparam logic [16:0] MOMENTUM_RST      = 17'd32768;  // 0.5
  localparam logic [16:0] ONE_Q16           = 17'd65536;  // 1.0

  // exp(-1) in Q0.32
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         index;
    logic signed [31:0] value;
    logic signed [31:0] grad_in;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [16:0]        activation;
    logic signed [31:0] gradient;
    logic signed [31:0] weight_out;
    logic               sum_done;
  } out_beat_t;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v[50:31] != {20{v[50]}}) begin
      r = v[50] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // restoring unsigned divide; elaboration-time only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid(-8 + 16k/entries) in Q0.16; elaboration-time only
  function automatic logic [16:0] sig_entry(input int k, input int entries);
    longint      n;
    logic [63:0] a, t, f, ip, sum, term, e, den, s;
    n = 64'(16 * k) - 64'(8 * entries);
    a = (n < 0) ? 64'(-n) : 64'(n);
    t = udiv64(a << 32, 64'(entries));
    ip = t >> 32;
    f = t & 64'hFFFF_FFFF;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int i = 1; i <= 20; i++) begin
      term = udiv64((term * f) >> 32, 64'(i));
      if ((i & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int j = 0; j < 9; j++) begin
      if (64'(j) < ip) sum = (sum * EXP_M1_Q32) >> 32;
    end
    e = sum;
    den = (64'd1 << 32) + e;
    s = udiv64(e * 64'd65536 + (den >> 1), den);
    if (n > 0) s = 64'd65536 - s;
    return s[16:0];
  endfunction

endpackage

FILE: rtl/snb_chan_if.sv
// ----------------------------------------------------------------------------
// snb_chan_if: valid/ready channel
// Carries one beat of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface snb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sigmoid_neuron_backprop_unit_top.sv
// ----------------------------------------------------------------------------
// sigmoid_neuron_backprop_unit_top: one sigmoid neuron with momentum backprop
// Forward input and hidden term beats take extra steps on the last beat.
// Throughput: one beat at a time; the single 33x33 multiplier sets the
//   step count of each command.
// Reset: async active low; clears sequencer, sum, activation, gradient and
//   loads default learning rate and momentum. Weight store is not cleared.
// ----------------------------------------------------------------------------
module sigmoid_neuron_backprop_unit_top #(
  parameter int MAX_INPUTS  = 64,
  parameter int SIG_ENTRIES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [snb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [snb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  snb_chan_if.sink                        in_i,
  snb_chan_if.source                      out_o
);

  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int KW = $clog2(SIG_ENTRIES);

  // sequencer: idle, or busy stepping through the command
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                state_q, state_d;
  logic [2:0]          step_q, step_d;
  snb_pkg::in_beat_t   beat_q;
  snb_pkg::out_beat_t  out_q, out_d;
  logic                out_valid_q;

  logic signed [47:0]  acc_q, acc_d;
  logic [16:0]         act_q, act_d;
  logic signed [31:0]  grad_q, grad_d;
  logic [16:0]         eta_q, alpha_q;

  // weight and delta store, one write and one registered read per cycle
  logic signed [31:0]  w_mem [MAX_INPUTS];
  logic signed [31:0]  dl_mem [MAX_INPUTS];
  logic signed [31:0]  w_rd_q, dl_rd_q;
  logic                mem_we;
  logic signed [31:0]  mem_wd_w, mem_wd_d;
  logic [AW-1:0]       rd_addr, wr_addr;

  // shared multiplier, product registered
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod_q;

  logic signed [49:0]  hp_q, hp_d, t1_q, t1_d;
  logic signed [31:0]  nd_q, nd_d;
  logic [16:0]         d_q, d_d;
  logic                sat_lo_q, sat_lo_d, sat_hi_q, sat_hi_d;

  // sigmoid table as ROM with registered read
  logic [16:0]         sig_rom [SIG_ENTRIES];
  logic [KW-1:0]       rom_addr;
  logic [16:0]         rom_q;

  logic                accept, fin, ok;
  logic signed [47:0]  acc_sum;
  logic [19:0]         acc_bias;
  logic signed [31:0]  w_cur;

  for (genvar k = 0; k < SIG_ENTRIES; k++) begin : g_sig
    localparam logic [16:0] SigVal = snb_pkg::sig_entry(k, SIG_ENTRIES);
    assign sig_rom[k] = SigVal;
  end

  assign in_i.ready  = (state_q == ST_IDLE) && !out_valid_q;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign rd_addr = AW'(in_i.data.index);
  assign wr_addr = AW'(beat_q.index);
  assign ok      = 32'(beat_q.index) < 32'(MAX_INPUTS);
  assign w_cur   = ok ? w_rd_q : 32'sd0;

  // running sum with the latest product, floor >> 16
  assign acc_sum  = snb_pkg::sat48(49'(acc_q) + 49'($signed(prod_q[63:16])));
  assign acc_bias = acc_q[19:0] + 20'h80000;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q + 3'd1;
    fin      = 1'b0;
    acc_d    = acc_q;
    act_d    = act_q;
    grad_d   = grad_q;
    hp_d     = hp_q;
    t1_d     = t1_q;
    nd_d     = nd_q;
    d_d      = d_q;
    sat_lo_d = sat_lo_q;
    sat_hi_d = sat_hi_q;
    rom_addr = '0;
    mul_a    = '0;
    mul_b    = '0;
    mem_we   = 1'b0;
    mem_wd_w = beat_q.value;
    mem_wd_d = '0;
    out_d    = '0;

    if (state_q == ST_BUSY) begin
      case (snb_pkg::cmd_e'(beat_q.cmd))
        snb_pkg::CMD_LOAD_WEIGHT: begin
          mem_we           = ok;
          out_d.weight_out = ok ? beat_q.value : 32'sd0;
          fin              = 1'b1;
        end
        snb_pkg::CMD_FORWARD_INPUT: begin
          out_d.weight_out = w_cur;
          case (step_q)
            3'd0: begin
              mul_a = 33'(beat_q.value);
              mul_b = 33'(w_cur);
            end
            3'd1: begin
              acc_d = acc_sum;
              fin   = !beat_q.last;
            end
            3'd2: begin
              sat_lo_d = acc_q < -48'sd524288;
              sat_hi_d = acc_q >= 48'sd524288;
              mul_a    = {13'd0, acc_bias};
              mul_b    = 33'(SIG_ENTRIES);
            end
            3'd3: begin
              rom_addr = sat_lo_q ? '0 :
                         sat_hi_q ? KW'(SIG_ENTRIES - 1) : prod_q[20 +: KW];
            end
            default: begin
              act_d          = rom_q;
              acc_d          = '0;
              out_d.sum_done = 1'b1;
              fin            = 1'b1;
            end
          endcase
        end
        snb_pkg::CMD_OUTPUT_GRADIENT: begin
          case (step_q)
            3'd0: begin
              mul_a = {16'd0, act_q};
              mul_b = {16'd0, snb_pkg::ONE_Q16 - act_q};
            end
            3'd1: begin
              mul_a = 33'(beat_q.value) - {16'd0, act_q};
              mul_b = {16'd0, prod_q[32:16]};
            end
            default: begin
              grad_d         = snb_pkg::sat32(51'($signed(prod_q[65:16])));
              out_d.sum_done = 1'b1;
              fin            = 1'b1;
            end
          endcase
        end
        snb_pkg::CMD_HIDDEN_TERM: begin
          case (step_q)
            3'd0: begin
              mul_a = 33'(beat_q.value);
              mul_b = 33'(beat_q.grad_in);
            end
            3'd1: begin
              acc_d = acc_sum;
              fin   = !beat_q.last;
              mul_a = {16'd0, act_q};
              mul_b = {16'd0, snb_pkg::ONE_Q16 - act_q};
            end
            3'd2: begin
              d_d   = prod_q[32:16];
              mul_a = 33'($signed(acc_q[47:16]));
              mul_b = {16'd0, prod_q[32:16]};
            end
            3'd3: begin
              hp_d  = prod_q[49:0];
              mul_a = {17'd0, acc_q[15:0]};
              mul_b = {16'd0, d_q};
            end
            default: begin
              grad_d = snb_pkg::sat32(51'(hp_q) + {33'd0, prod_q[33:16]});
              acc_d          = '0;
              out_d.sum_done = 1'b1;
              fin            = 1'b1;
            end
          endcase
        end
        snb_pkg::CMD_UPDATE_INPUT: begin
          case (step_q)
            3'd0: begin
              fin   = !ok;
              mul_a = 33'(beat_q.value);
              mul_b = 33'(grad_q);
            end
            3'd1: begin
              // p = prod >> 16, split into signed high and unsigned low halves
              mul_a = 33'($signed(prod_q[63:32]));
              mul_b = {16'd0, eta_q};
              hp_d  = 50'({17'd0, prod_q[31:16]});
            end
            3'd2: begin
              mul_a = {17'd0, hp_q[15:0]};
              mul_b = {16'd0, eta_q};
              hp_d  = prod_q[49:0];
            end
            3'd3: begin
              t1_d  = hp_q + 50'({32'd0, prod_q[33:16]});
              mul_a = {16'd0, alpha_q};
              mul_b = 33'(dl_rd_q);
            end
            3'd4: begin
              nd_d = snb_pkg::sat32(51'(t1_q) + 51'($signed(prod_q[48:16])));
            end
            default: begin
              mem_we           = 1'b1;
              mem_wd_d         = nd_q;
              mem_wd_w         = snb_pkg::sat32(51'(w_cur) + 51'(nd_q));
              out_d.weight_out = mem_wd_w;
              fin              = 1'b1;
            end
          endcase
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end

    out_d.activation = act_d;
    out_d.gradient   = grad_d;
    if (fin) begin
      state_d = ST_IDLE;
      step_d  = '0;
    end else if (state_q == ST_IDLE) begin
      step_d = '0;
      if (accept) state_d = ST_BUSY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      act_q       <= '0;
      grad_q      <= '0;
      eta_q       <= snb_pkg::LEARNING_RATE_RST;
      alpha_q     <= snb_pkg::MOMENTUM_RST;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      acc_q   <= acc_d;
      act_q   <= act_d;
      grad_q  <= grad_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          snb_pkg::REG_LEARNING_RATE: eta_q   <= cfg_wdata_i;
          snb_pkg::REG_MOMENTUM:      alpha_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    prod_q   <= mul_a * mul_b;
    hp_q     <= hp_d;
    t1_q     <= t1_d;
    nd_q     <= nd_d;
    d_q      <= d_d;
    sat_lo_q <= sat_lo_d;
    sat_hi_q <= sat_hi_d;
    rom_q    <= sig_rom[rom_addr];
    if (accept) beat_q <= in_i.data;
    if (fin) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_rd_q  <= w_mem[rd_addr];
      dl_rd_q <= dl_mem[rd_addr];
    end
    if (mem_we) begin
      w_mem[wr_addr]  <= mem_wd_w;
      dl_mem[wr_addr] <= mem_wd_d;
    end
  end

`ifndef SYNTHESIS
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q <= snb_pkg::ONE_Q16)
    else $error("activation above 1.0");

  a_load_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.data.cmd == snb_pkg::CMD_LOAD_WEIGHT) |-> ##2 out_valid_q)
    else $error("load beat did not complete in two cycles");

  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && beat_q.last && (beat_q.cmd == snb_pkg::CMD_FORWARD_INPUT ||
     beat_q.cmd == snb_pkg::CMD_HIDDEN_TERM)) |=> acc_q == 48'sd0)
    else $error("sum not cleared after last term");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 3'd5)
    else $error("sequencer step out of range");
`endif

endmodule
